FILE: sv/topological_sort_kahn_defines.svh
// assertion macros for the topological sort block
`ifndef TOPOLOGICAL_SORT_KAHN_DEFINES_SVH
`define TOPOLOGICAL_SORT_KAHN_DEFINES_SVH
// assert that a implies b on the same edge
`define TSK_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next edge
`define TSK_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: sv/tsk_pkg.sv
// ----------------------------------------------------------------------------
// tsk_pkg
// types and constants shared by the topological sort block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tsk_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int ETotW = $clog2(MaxEdges + 1);
  localparam int NCntW = $clog2(MaxNodes + 1);
  localparam int DegW = ETotW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_RUN = 2'd1,
    OP_CLR = 2'd2,
    OP_NOP = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZERO,
    ST_CNT_RD,
    ST_CNT_DEG,
    ST_CNT_UPD,
    ST_SEED,
    ST_POP,
    ST_SCAN_RD,
    ST_SCAN_DEG,
    ST_SCAN_UPD,
    ST_FINAL
  } state_e;

  // control from the sequencer to the degree/queue unit
  typedef struct packed {
    logic             deg_wr;
    logic [NodeW-1:0] deg_addr;
    logic [DegW-1:0]  deg_wdata;
    logic             q_push;
    logic [NodeW-1:0] q_wdata;
    logic             q_reset;
    logic             q_pop;
  } dq_ctrl_t;

  // status back from the degree/queue unit
  typedef struct packed {
    logic [DegW-1:0]  deg_rdata;
    logic [NodeW-1:0] q_rdata;
    logic             q_empty;
  } dq_stat_t;
endpackage

FILE: sv/tsk_if.sv
// ----------------------------------------------------------------------------
// tsk_if
// valid/ready channels of the topological sort block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface tsk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] from_node;
  logic [5:0] to_node;
  modport source (output valid, opcode, from_node, to_node, input ready);
  modport sink (input valid, opcode, from_node, to_node, output ready);
endinterface

interface tsk_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] node_id;
  logic       node_valid;
  logic       last;
  logic       has_cycle;
  logic       overflow;
  modport source (output valid, node_id, node_valid, last, has_cycle, overflow,
                  input ready);
  modport sink (input valid, node_id, node_valid, last, has_cycle, overflow,
                output ready);
endinterface

interface tsk_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/topological_sort_kahn.sv
// ----------------------------------------------------------------------------
// topological_sort_kahn
// kahn topological sort over a stored edge list
// ----------------------------------------------------------------------------
//  channel  dir  transaction
//  in_ch    in   opcode, from_node, to_node
//  out_ch   out  node_id, node_valid, last, has_cycle, overflow
//  cfg_ch   in   node_count write, taken while idle
// add, clear and ignored opcodes are taken back to back.
// a run walks the single edge memory read port once for counting and once per
// popped node, over every stored edge.
// input is not ready during a run; the next pop waits while a result waits in
// the output register. reset clears control state only; no memory clearing pass.
`timescale 1ns / 1ps
module topological_sort_kahn import tsk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tsk_in_if.sink    in_ch,
  tsk_out_if.source out_ch,
  tsk_cfg_if.sink   cfg_ch
);
  state_e state_q, state_d;
  logic [6:0]       ncfg_q;
  logic [NCntW-1:0] n_eff;
  logic [ETotW-1:0] etot_q, etot_d;
  logic             drop_q, drop_d;
  logic [ETotW-1:0] eidx_q, eidx_d;
  logic [NCntW-1:0] vidx_q, vidx_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [NCntW-1:0] emit_q, emit_d;
  logic             ovalid_q, ovalid_d;
  logic [NodeW-1:0] oid_q, oid_d;
  logic             onv_q, onv_d, olast_q, olast_d, ocyc_q, ocyc_d, oovf_q, oovf_d;
  logic             pend_q, pend_d;
  logic [NodeW-1:0] esrc, edst;
  logic             mem_wr, edge_ok, in_fire, out_free, pop_go, pop_ok;
  dq_ctrl_t         dq_ctrl;
  dq_stat_t         dq_stat;

  assign n_eff = (ncfg_q > 7'(MaxNodes)) ? NCntW'(MaxNodes) : ncfg_q[NCntW-1:0];
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_free = !ovalid_q || out_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign cfg_ch.ready = (state_q == ST_IDLE);
  assign edge_ok = ({1'b0, in_ch.from_node} < n_eff) && ({1'b0, in_ch.to_node} < n_eff)
                   && (etot_q < ETotW'(MaxEdges));
  assign mem_wr = in_fire && (in_ch.opcode == OP_ADD) && edge_ok;

  // a further node can be popped; the output register must be free for the held node
  assign pop_go = !dq_stat.q_empty && (emit_q != NCntW'(MaxNodes));
  assign pop_ok = pop_go && ((emit_q == '0) || out_free);

  tsk_edge_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .waddr_i (etot_q[EdgeW-1:0]),
    .wsrc_i  (in_ch.from_node),
    .wdst_i  (in_ch.to_node),
    .raddr_i (eidx_q[EdgeW-1:0]),
    .rsrc_o  (esrc),
    .rdst_o  (edst)
  );

  tsk_deg_queue u_dq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dq_ctrl),
    .stat_o (dq_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire && in_ch.opcode == OP_RUN) state_d = ST_ZERO;
      ST_ZERO:     if (vidx_q == NCntW'(MaxNodes - 1)) state_d = ST_CNT_RD;
      ST_CNT_RD:   state_d = (eidx_q >= etot_q) ? ST_SEED : ST_CNT_DEG;
      ST_CNT_DEG:  state_d = ST_CNT_UPD;
      ST_CNT_UPD:  state_d = ST_CNT_RD;
      ST_SEED:     if (pend_q && vidx_q >= n_eff) state_d = ST_POP;
      ST_POP: begin
        if (!pop_go) state_d = ST_FINAL;
        else if (pop_ok) state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD:  state_d = (eidx_q >= etot_q) ? ST_POP : ST_SCAN_DEG;
      ST_SCAN_DEG: state_d = ST_SCAN_UPD;
      ST_SCAN_UPD: state_d = ST_SCAN_RD;
      ST_FINAL:    if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    etot_d = etot_q; drop_d = drop_q; eidx_d = eidx_q; vidx_d = vidx_q;
    node_d = node_q; emit_d = emit_q; pend_d = 1'b0;
    ovalid_d = ovalid_q && !out_ch.ready;
    oid_d = oid_q; onv_d = onv_q; olast_d = olast_q; ocyc_d = ocyc_q; oovf_d = oovf_q;
    dq_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            OP_ADD: if (edge_ok) etot_d = etot_q + 1'b1; else drop_d = 1'b1;
            OP_RUN: begin vidx_d = '0; eidx_d = '0; emit_d = '0; end
            OP_CLR: begin etot_d = '0; drop_d = 1'b0; end
            default: ;
          endcase
        end
      end
      ST_ZERO: begin
        dq_ctrl.deg_wr = 1'b1;
        dq_ctrl.deg_addr = vidx_q[NodeW-1:0];
        vidx_d = vidx_q + 1'b1;
        if (vidx_q == NCntW'(MaxNodes - 1)) vidx_d = '0;
      end
      ST_CNT_RD: begin
        // memory read of edge eidx lands next cycle
        dq_ctrl.q_reset = 1'b1;
      end
      ST_CNT_DEG: begin
        // degree of target read, lands next cycle
        dq_ctrl.deg_addr = edst;
      end
      ST_CNT_UPD: begin
        dq_ctrl.deg_addr = edst;
        eidx_d = eidx_q + 1'b1;
        if ({1'b0, esrc} < n_eff && {1'b0, edst} < n_eff) begin
          dq_ctrl.deg_wr = 1'b1;
          dq_ctrl.deg_wdata = dq_stat.deg_rdata + 1'b1;
        end
      end
      ST_SEED: begin
        // two-phase: address, then compare
        dq_ctrl.deg_addr = vidx_q[NodeW-1:0];
        if (!pend_q) pend_d = 1'b1;
        else if (vidx_q < n_eff) begin
          if (dq_stat.deg_rdata == '0) begin
            dq_ctrl.q_push = 1'b1;
            dq_ctrl.q_wdata = vidx_q[NodeW-1:0];
          end
          vidx_d = vidx_q + 1'b1;
        end
      end
      ST_POP: begin
        if (pop_ok) begin
          dq_ctrl.q_pop = 1'b1;
          node_d = dq_stat.q_rdata;
          emit_d = emit_q + 1'b1;
          eidx_d = '0;
          // another node follows, so the held one is not last
          if (emit_q != '0) begin
            ovalid_d = 1'b1;
            oid_d = node_q; onv_d = 1'b1; olast_d = 1'b0; ocyc_d = 1'b0; oovf_d = 1'b0;
          end
        end
      end
      ST_SCAN_RD: ;
      ST_SCAN_DEG: begin
        dq_ctrl.deg_addr = edst;
      end
      ST_SCAN_UPD: begin
        dq_ctrl.deg_addr = edst;
        eidx_d = eidx_q + 1'b1;
        if (esrc == node_q && {1'b0, edst} < n_eff && dq_stat.deg_rdata != '0) begin
          dq_ctrl.deg_wr = 1'b1;
          dq_ctrl.deg_wdata = dq_stat.deg_rdata - 1'b1;
          if (dq_stat.deg_rdata == DegW'(1)) begin
            dq_ctrl.q_push = 1'b1;
            dq_ctrl.q_wdata = edst;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oid_d = node_q; onv_d = (emit_q != '0);
          if (emit_q == '0) oid_d = '0;
          olast_d = 1'b1; ocyc_d = (emit_q != n_eff); oovf_d = drop_q;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid = ovalid_q;
  assign out_ch.node_id = oid_q;
  assign out_ch.node_valid = onv_q;
  assign out_ch.last = olast_q;
  assign out_ch.has_cycle = ocyc_q;
  assign out_ch.overflow = oovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ncfg_q <= 7'd64; etot_q <= '0; drop_q <= 1'b0;
      eidx_q <= '0; vidx_q <= '0; emit_q <= '0; pend_q <= 1'b0; ovalid_q <= 1'b0;
      node_q <= '0;
      oid_q <= '0; onv_q <= 1'b0; olast_q <= 1'b0; ocyc_q <= 1'b0; oovf_q <= 1'b0;
    end else begin
      state_q <= state_d; etot_q <= etot_d; drop_q <= drop_d; eidx_q <= eidx_d;
      vidx_q <= vidx_d; emit_q <= emit_d; pend_q <= pend_d; node_q <= node_d;
      ovalid_q <= ovalid_d;
      oid_q <= oid_d; onv_q <= onv_d; olast_q <= olast_d; ocyc_q <= ocyc_d;
      oovf_q <= oovf_d;
      if (cfg_ch.valid && cfg_ch.ready) ncfg_q <= cfg_ch.data;
    end
  end
endmodule

FILE: sv/tsk_edge_mem.sv
// ----------------------------------------------------------------------------
// tsk_edge_mem
// edge store: one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tsk_edge_mem import tsk_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_i,
  input  logic [EdgeW-1:0] waddr_i,
  input  logic [NodeW-1:0] wsrc_i,
  input  logic [NodeW-1:0] wdst_i,
  input  logic [EdgeW-1:0] raddr_i,
  output logic [NodeW-1:0] rsrc_o,
  output logic [NodeW-1:0] rdst_o
);
  logic [2*NodeW-1:0] mem [MaxEdges];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i) mem[waddr_i] <= {wsrc_i, wdst_i};
    {rsrc_o, rdst_o} <= mem[raddr_i];
  end
endmodule

FILE: sv/tsk_deg_queue.sv
// ----------------------------------------------------------------------------
// tsk_deg_queue
// in-degree memory and ready fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tsk_deg_queue import tsk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dq_ctrl_t ctrl_i,
  output dq_stat_t stat_o
);
  logic [DegW-1:0]  deg_mem [MaxNodes];
  logic [NodeW-1:0] q_mem [MaxNodes];
  logic [NCntW-1:0] head_q, head_d, tail_q, tail_d;
  logic [NodeW-1:0] q_rd_q;
  logic [DegW-1:0]  deg_rd_q;

  // degree memory, read data registered
  always_ff @(posedge clk_i) begin
    if (ctrl_i.deg_wr) deg_mem[ctrl_i.deg_addr] <= ctrl_i.deg_wdata;
    deg_rd_q <= deg_mem[ctrl_i.deg_addr];
  end

  // queue memory; head entry read registered
  always_ff @(posedge clk_i) begin
    if (ctrl_i.q_push && tail_q < NCntW'(MaxNodes))
      q_mem[tail_q[NodeW-1:0]] <= ctrl_i.q_wdata;
    q_rd_q <= q_mem[head_q[NodeW-1:0]];
  end

  // pointer update
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.q_reset) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (ctrl_i.q_pop) head_d = head_q + 1'b1;
      if (ctrl_i.q_push && tail_q < NCntW'(MaxNodes)) tail_d = tail_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  assign stat_o.deg_rdata = deg_rd_q;
  assign stat_o.q_rdata = q_rd_q;
  assign stat_o.q_empty = (head_q == tail_q);
endmodule

FILE: sv/tsk_checker.sv
// ----------------------------------------------------------------------------
// tsk_checker
// port level checks of the topological sort block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "topological_sort_kahn_defines.svh"
module tsk_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_node_valid,
  input logic out_last,
  input logic out_has_cycle,
  input logic out_overflow
);
  // status-only result is always the last one
  `TSK_ASSERT_IMP(a_status_last, clk_i, rst_ni, out_valid && !out_node_valid, out_last)
  // flags stay low before the last result
  `TSK_ASSERT_IMP(a_flags_low, clk_i, rst_ni, out_valid && !out_last,
                  !out_has_cycle && !out_overflow)
  // a stalled result holds
  `TSK_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  // no input taken while a result that is not the last is pending
  `TSK_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid && !out_last, !in_ready)
endmodule

bind topological_sort_kahn tsk_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_node_valid (out_ch.node_valid),
  .out_last       (out_ch.last),
  .out_has_cycle  (out_ch.has_cycle),
  .out_overflow   (out_ch.overflow)
);
